[rtl/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared widths, fixed-point constants, arctangent table and the Q30 multiply
// used by the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

  // cordic depth, used by both the rotation and the vectoring pipes
  localparam int CORDIC_STAGES = 24;

  // internal angle / sine / cosine word, signed Q30 with headroom
  localparam int ANG_W = 34;
  // chord term h, unsigned Q30 in [0,1]
  localparam int H_W = 31;
  // radicand (h << 30) and its root
  localparam int RAD_W = 61;
  localparam int ROOT_W = 31;
  localparam int SQ_STAGES = (RAD_W + 1) / 2;
  // scaling product and result
  localparam int SCALE_W = 29;
  localparam int PROD_W = ROOT_W + SCALE_W;
  localparam int DIST_W = 30;
  localparam int FRAC_W = 30;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t HALF_PI_Q30 = 34'sd1686629713;
  localparam ang_t PI_Q30 = 34'sd3373259426;
  localparam ang_t GAIN_INV_Q30 = 34'sd652032874;
  localparam ang_t ONE_Q30 = 34'sd1073741824;
  localparam logic [SCALE_W-1:0] TWO_R_Q16 = 29'd518882722;

  // atan(2^-i) in Q30, truncated
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
  };

  function automatic ang_t atan_q30(input logic [4:0] idx);
    atan_q30 = ang_t'({2'b00, ATAN_TAB[idx]});
  endfunction

  // sign-magnitude Q30 product, truncated toward zero
  function automatic ang_t mul_q30(input ang_t a, input ang_t b);
    logic neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [ANG_W-1:0] q;
    neg = a[ANG_W-1] ^ b[ANG_W-1];
    ma = a[ANG_W-1] ? 32'(-a) : 32'(a);
    mb = b[ANG_W-1] ? 32'(-b) : 32'(b);
    p = {32'b0, ma} * {32'b0, mb};
    q = ANG_W'(p >> 30);
    mul_q30 = neg ? ang_t'(-q) : ang_t'(q);
  endfunction

endpackage

[rtl/hvd_if.sv]
// ----------------------------------------------------------------------------
// hvd_if
// Valid/ready channels for coordinate pair requests and distance results.
// ----------------------------------------------------------------------------
interface hvd_in_if;
  logic valid;
  logic ready;
  logic signed [30:0] lat_a;
  logic signed [31:0] lng_a;
  logic signed [30:0] lat_b;
  logic signed [31:0] lng_b;
  modport source(output valid, lat_a, lng_a, lat_b, lng_b, input ready);
  modport sink(input valid, lat_a, lng_a, lat_b, lng_b, output ready);
endinterface

interface hvd_out_if;
  logic valid;
  logic ready;
  logic [29:0] distance;
  modport source(output valid, distance, input ready);
  modport sink(input valid, distance, output ready);
endinterface

[rtl/hvd_rot.sv]
// ----------------------------------------------------------------------------
// hvd_rot
// Rotation-mode cordic lane: range reduction by pi, then one register stage
// per iteration, giving sine and cosine in Q30.
// ----------------------------------------------------------------------------
module hvd_rot (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vld_i,
  input  hvd_pkg::ang_t ang,
  output logic         vld_o,
  output hvd_pkg::ang_t sin_o,
  output hvd_pkg::ang_t cos_o
);

  localparam int N = hvd_pkg::CORDIC_STAGES;

  hvd_pkg::ang_t t_red;
  logic neg_red;

  hvd_pkg::ang_t x [0:N];
  hvd_pkg::ang_t y [0:N];
  hvd_pkg::ang_t z [0:N];
  logic neg [0:N];
  logic vld [0:N];

  // move the angle by pi into +-pi/2, flipping the sign once
  always_comb begin
    priority if (ang > hvd_pkg::HALF_PI_Q30) begin
      t_red = ang - hvd_pkg::PI_Q30;
      neg_red = 1'b1;
    end else if (ang < -hvd_pkg::HALF_PI_Q30) begin
      t_red = ang + hvd_pkg::PI_Q30;
      neg_red = 1'b1;
    end else begin
      t_red = ang;
      neg_red = 1'b0;
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= hvd_pkg::GAIN_INV_Q30;
      y[0] <= '0;
      z[0] <= t_red;
      neg[0] <= neg_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_i;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    hvd_pkg::ang_t dx;
    hvd_pkg::ang_t dy;
    hvd_pkg::ang_t at;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    assign at = hvd_pkg::atan_q30(5'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][hvd_pkg::ANG_W-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - at;
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + at;
        end
        neg[i+1] <= neg[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  // apply the sign from range reduction
  assign sin_o = neg[N] ? -y[N] : y[N];
  assign cos_o = neg[N] ? -x[N] : x[N];
  assign vld_o = vld[N];

endmodule

[rtl/hvd_chord.sv]
// ----------------------------------------------------------------------------
// hvd_chord
// Chord term h = s_lat^2 + s_lng^2 * cos_a * cos_b, both squares in the first
// stage and one multiply per later stage, clamped to [0,1].
// ----------------------------------------------------------------------------
module hvd_chord (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    vld_i,
  input  hvd_pkg::ang_t           s_lat,
  input  hvd_pkg::ang_t           s_lng,
  input  hvd_pkg::ang_t           c_a,
  input  hvd_pkg::ang_t           c_b,
  output logic                    vld_o,
  output logic [hvd_pkg::H_W-1:0] h
);

  hvd_pkg::ang_t p_lat1, p_lng1, c_a1, c_b1;
  hvd_pkg::ang_t p_lat2, q2, c_b2;
  hvd_pkg::ang_t p_lat3, r3;
  hvd_pkg::ang_t sum;
  logic [hvd_pkg::H_W-1:0] h_clamp;
  logic [1:4] vld;

  // sum and clamp to [0,1]
  always_comb begin
    sum = p_lat3 + r3;
    priority if (sum[hvd_pkg::ANG_W-1]) begin
      h_clamp = '0;
    end else if (sum > hvd_pkg::ONE_Q30) begin
      h_clamp = hvd_pkg::H_W'(hvd_pkg::ONE_Q30);
    end else begin
      h_clamp = hvd_pkg::H_W'(sum);
    end
  end

  // multiply stages
  always_ff @(posedge clk) begin
    if (en) begin
      p_lat1 <= hvd_pkg::mul_q30(s_lat, s_lat);
      p_lng1 <= hvd_pkg::mul_q30(s_lng, s_lng);
      c_a1 <= c_a;
      c_b1 <= c_b;
      p_lat2 <= p_lat1;
      q2 <= hvd_pkg::mul_q30(p_lng1, c_a1);
      c_b2 <= c_b1;
      p_lat3 <= p_lat2;
      r3 <= hvd_pkg::mul_q30(q2, c_b2);
      h <= h_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld_i, vld[1:3]};
    end
  end

  assign vld_o = vld[4];

endmodule

[rtl/hvd_sqrt.sv]
// ----------------------------------------------------------------------------
// hvd_sqrt
// Exact floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module hvd_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [hvd_pkg::RAD_W-1:0]  rad,
  output logic                       vld_o,
  output logic [hvd_pkg::ROOT_W-1:0] root
);

  localparam int S = hvd_pkg::SQ_STAGES;
  localparam int W = hvd_pkg::RAD_W;

  logic [W-1:0] v [1:S];
  logic [W-1:0] r [1:S];
  logic vld [1:S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [W-1:0] v_cur;
    logic [W-1:0] r_cur;
    logic vld_cur;
    logic [W:0] trial;
    logic [W-1:0] b;

    if (k == 0) begin : g_first
      assign v_cur = rad;
      assign r_cur = '0;
      assign vld_cur = vld_i;
    end else begin : g_next
      assign v_cur = v[k];
      assign r_cur = r[k];
      assign vld_cur = vld[k];
    end

    assign b = W'(1) << (W - 1 - 2 * k);
    assign trial = {1'b0, r_cur} + {1'b0, b};

    // try this root bit
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, v_cur} >= trial) begin
          v[k+1] <= W'({1'b0, v_cur} - trial);
          r[k+1] <= (r_cur >> 1) + b;
        end else begin
          v[k+1] <= v_cur;
          r[k+1] <= r_cur >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld_cur;
      end
    end
  end

  assign root = r[S][hvd_pkg::ROOT_W-1:0];
  assign vld_o = vld[S];

endmodule

[rtl/hvd_vec.sv]
// ----------------------------------------------------------------------------
// hvd_vec
// Vectoring-mode cordic for atan2(y, x), one register stage per iteration,
// negative angle clamped to zero.
// ----------------------------------------------------------------------------
module hvd_vec (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [hvd_pkg::ROOT_W-1:0] y_in,
  input  logic [hvd_pkg::ROOT_W-1:0] x_in,
  output logic                       vld_o,
  output logic [hvd_pkg::ROOT_W-1:0] ang
);

  localparam int N = hvd_pkg::CORDIC_STAGES;

  hvd_pkg::ang_t x [1:N];
  hvd_pkg::ang_t y [1:N];
  hvd_pkg::ang_t z [1:N];
  logic vld [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    hvd_pkg::ang_t x_cur, y_cur, z_cur;
    hvd_pkg::ang_t dx, dy, at;
    logic vld_cur;

    if (i == 0) begin : g_first
      assign x_cur = hvd_pkg::ang_t'({3'b000, x_in});
      assign y_cur = hvd_pkg::ang_t'({3'b000, y_in});
      assign z_cur = '0;
      assign vld_cur = vld_i;
    end else begin : g_next
      assign x_cur = x[i];
      assign y_cur = y[i];
      assign z_cur = z[i];
      assign vld_cur = vld[i];
    end

    assign dx = y_cur >>> i;
    assign dy = x_cur >>> i;
    assign at = hvd_pkg::atan_q30(5'(i));

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_cur > 0) begin
          x[i+1] <= x_cur + dx;
          y[i+1] <= y_cur - dy;
          z[i+1] <= z_cur + at;
        end else begin
          x[i+1] <= x_cur - dx;
          y[i+1] <= y_cur + dy;
          z[i+1] <= z_cur - at;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld_cur;
      end
    end
  end

  assign ang = z[N][hvd_pkg::ANG_W-1] ? '0 : z[N][hvd_pkg::ROOT_W-1:0];
  assign vld_o = vld[N];

endmodule

[rtl/haversine_distance.sv]
// pipeline: rotation lanes, chord product, square roots, atan2, then product and result registers
// throughput: one request per cycle; every stage is a register that advances
// together, and the whole pipe holds while a finished result is not taken
// reset: synchronous, clears only the valid bits; no state survives a request
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points in Q3.29 radians, as Q14.16 miles,
// through cordic sine/cosine, chord product, square roots and cordic atan2.
// ----------------------------------------------------------------------------
module haversine_distance (
  input  logic       clk,
  input  logic       rst,
  hvd_in_if.sink     in_ch,
  hvd_out_if.source  out_ch
);

  logic en;
  logic out_vld;
  logic [hvd_pkg::DIST_W-1:0] dist_r;

  hvd_pkg::ang_t d_lat, d_lng, t_a, t_b;
  hvd_pkg::ang_t s_lat, s_lng, c_a, c_b;
  logic v_lat, v_lng, v_a, v_b;

  logic v_h;
  logic [hvd_pkg::H_W-1:0] h;
  logic [hvd_pkg::RAD_W-1:0] rad_h, rad_1h;
  logic v_rh, v_r1h;
  logic [hvd_pkg::ROOT_W-1:0] r_h, r_1h;
  logic v_ang;
  logic [hvd_pkg::ROOT_W-1:0] ang;

  logic v_prod;
  logic [hvd_pkg::PROD_W-1:0] prod;
  logic [hvd_pkg::PROD_W:0] rnd;
  logic [hvd_pkg::PROD_W-hvd_pkg::FRAC_W:0] d_full;
  logic [hvd_pkg::DIST_W-1:0] d_sat;

  // whole pipe advances unless the result register is held
  assign en = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  // half differences and latitudes, Q30
  assign d_lat = hvd_pkg::ang_t'(in_ch.lat_a) - hvd_pkg::ang_t'(in_ch.lat_b);
  assign d_lng = hvd_pkg::ang_t'(in_ch.lng_a) - hvd_pkg::ang_t'(in_ch.lng_b);
  assign t_a = hvd_pkg::ang_t'(in_ch.lat_a) <<< 1;
  assign t_b = hvd_pkg::ang_t'(in_ch.lat_b) <<< 1;

  // four sine/cosine lanes
  hvd_rot u_rot_lat (
    .clk(clk), .rst(rst), .en(en), .vld_i(in_ch.valid), .ang(d_lat),
    .vld_o(v_lat), .sin_o(s_lat), .cos_o()
  );
  hvd_rot u_rot_lng (
    .clk(clk), .rst(rst), .en(en), .vld_i(in_ch.valid), .ang(d_lng),
    .vld_o(v_lng), .sin_o(s_lng), .cos_o()
  );
  hvd_rot u_rot_a (
    .clk(clk), .rst(rst), .en(en), .vld_i(in_ch.valid), .ang(t_a),
    .vld_o(v_a), .sin_o(), .cos_o(c_a)
  );
  hvd_rot u_rot_b (
    .clk(clk), .rst(rst), .en(en), .vld_i(in_ch.valid), .ang(t_b),
    .vld_o(v_b), .sin_o(), .cos_o(c_b)
  );

  // chord term
  hvd_chord u_chord (
    .clk(clk), .rst(rst), .en(en), .vld_i(v_lat & v_lng & v_a & v_b),
    .s_lat(s_lat), .s_lng(s_lng), .c_a(c_a), .c_b(c_b),
    .vld_o(v_h), .h(h)
  );

  // roots of h and 1-h, both scaled by 2^30
  assign rad_h = {h, {hvd_pkg::FRAC_W{1'b0}}};
  assign rad_1h = {hvd_pkg::H_W'(hvd_pkg::ONE_Q30) - h, {hvd_pkg::FRAC_W{1'b0}}};

  hvd_sqrt u_sqrt_h (
    .clk(clk), .rst(rst), .en(en), .vld_i(v_h), .rad(rad_h),
    .vld_o(v_rh), .root(r_h)
  );
  hvd_sqrt u_sqrt_1h (
    .clk(clk), .rst(rst), .en(en), .vld_i(v_h), .rad(rad_1h),
    .vld_o(v_r1h), .root(r_1h)
  );

  // central angle
  hvd_vec u_vec (
    .clk(clk), .rst(rst), .en(en), .vld_i(v_rh & v_r1h),
    .y_in(r_h), .x_in(r_1h), .vld_o(v_ang), .ang(ang)
  );

  // round and saturate the scaled angle
  always_comb begin
    rnd = {1'b0, prod} + ((hvd_pkg::PROD_W + 1)'(1) << (hvd_pkg::FRAC_W - 1));
    d_full = rnd[hvd_pkg::PROD_W:hvd_pkg::FRAC_W];
    d_sat = (d_full > {1'b0, {hvd_pkg::DIST_W{1'b1}}}) ? {hvd_pkg::DIST_W{1'b1}}
                                                        : hvd_pkg::DIST_W'(d_full);
  end

  // scale by the diameter, then result register
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= hvd_pkg::PROD_W'(ang) * hvd_pkg::PROD_W'(hvd_pkg::TWO_R_Q16);
      dist_r <= d_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_prod <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v_prod <= v_ang;
      out_vld <= v_prod;
    end
  end

  assign out_ch.valid = out_vld;
  assign out_ch.distance = dist_r;

`ifndef ASSERT_OFF
  // a held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_ch.ready) |-> !in_ch.ready)
    else $error("request taken while result held");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid after reset");

  // lanes stay aligned
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (v_lat == v_a) && (v_lng == v_b) && (v_lat == v_lng) && (v_rh == v_r1h))
    else $error("pipeline lanes out of step");
`endif

endmodule
